// ----- rtl/core/bncd_pkg.sv -----
// Shared types and constants of the binary neighbor-count denoise block.
`default_nettype none

package bncd_pkg;

    // Configuration port geometry.
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;

    // Field widths of the configuration registers.
    localparam int unsigned DIM_W = 12;
    localparam int unsigned THR_W = 4;
    localparam int unsigned BRD_W = 4;

    // Smallest frame dimension the block works with.
    localparam int unsigned DIM_MIN = 16;

    // Reset values of the configuration registers.
    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH    = 12'd640;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT   = 12'd480;
    localparam logic [THR_W-1:0] RST_HIGH_THRESHOLD = 4'd5;
    localparam logic [THR_W-1:0] RST_LOW_THRESHOLD  = 4'd2;
    localparam logic [BRD_W-1:0] RST_BORDER_WIDTH   = 4'd5;

    // One line store word: bit 1 is the older line, bit 0 the newer line.
    localparam int unsigned LS_W = 2;

    // Width of the count of neighbors around the center of the 3x3 window.
    localparam int unsigned NB_CNT_W = 4;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH    = 3'd0,
        CFG_IMAGE_HEIGHT   = 3'd1,
        CFG_HIGH_THRESHOLD = 3'd2,
        CFG_LOW_THRESHOLD  = 3'd3,
        CFG_BORDER_WIDTH   = 3'd4
    } t_cfg_idx;

endpackage

`default_nettype wire

// ----- rtl/core/bncd_line_store.sv -----
// Two-line store memory with registered read and write-to-read forwarding.
`default_nettype none

module bncd_line_store #(
    parameter int unsigned DEPTH = 2048,
    parameter int unsigned AW    = 11
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_rd_en,
    input  wire  [AW-1:0]              i_rd_addr,
    input  wire                        i_wr_en,
    input  wire  [AW-1:0]              i_wr_addr,
    input  wire  [bncd_pkg::LS_W-1:0]  i_wr_data,
    output logic [bncd_pkg::LS_W-1:0]  o_rd_data
);

    logic [bncd_pkg::LS_W-1:0] r_mem [DEPTH];
    logic [bncd_pkg::LS_W-1:0] r_rd_data;
    logic [bncd_pkg::LS_W-1:0] r_fwd_data;
    logic                      r_fwd_hit;

    // Memory array: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // A read that collides with a write in the same cycle takes the new data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/core/binary_neighbor_count_denoise.sv -----
// Top level of the binary 3x3 neighbor-count denoise filter.
//
// The block takes one binary pixel per clock in raster order, unless o_stall
// holds it, and returns the filtered pixel one line plus one pixel later; flush
// items push out the tail of a frame. Each accepted item reads its column from
// a two-line store memory in the accept cycle and writes the shifted column
// back as it leaves the modify stage, where the 3x3 window is updated and the
// neighbor count is compared; the result is registered in the output register
// as its releasing item leaves the modify stage. The sustained rate is one
// item per clock when nothing stalls, set by the single read and single write
// port of the line store. After the frame width is made smaller while the input
// column counter lies beyond it, the input stalls while the width is subtracted
// from the counter. The line store needs no clearing pass after reset.
`default_nettype none

module binary_neighbor_count_denoise #(
    parameter int unsigned MAX_WIDTH  = 2048,
    parameter int unsigned MAX_HEIGHT = 2048
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // Configuration write port.
    input  wire                                i_cfg_we,
    input  wire  [bncd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [bncd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Input item channel.
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire                                i_pixel_in,
    input  wire                                i_start_frame,
    input  wire                                i_flush,
    // Result item channel.
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic                               o_pixel_out,
    output logic                               o_frame_end
);

    localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned XW = (CW > bncd_pkg::DIM_W) ? CW : bncd_pkg::DIM_W;
    localparam int unsigned YW = (RW > bncd_pkg::DIM_W) ? RW : bncd_pkg::DIM_W;

    // Configuration registers.
    logic [bncd_pkg::DIM_W-1:0] r_image_width;
    logic [bncd_pkg::DIM_W-1:0] r_image_height;
    logic [bncd_pkg::THR_W-1:0] r_high_threshold;
    logic [bncd_pkg::THR_W-1:0] r_low_threshold;
    logic [bncd_pkg::BRD_W-1:0] r_border_width;

    // Raster counters.
    logic [CW-1:0] r_in_col,  n_in_col;
    logic [RW-1:0] r_in_row,  n_in_row;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [RW-1:0] r_out_row, n_out_row;

    // Read-modify-write stage.
    logic          r_s1_valid;
    logic          r_s1_emit;
    logic          r_s1_inside;
    logic          r_s1_end;
    logic          r_s1_pix;
    logic [AW-1:0] r_s1_addr;
    logic [8:0]    r_window;

    // Output register.
    logic r_out_valid;
    logic r_out_pix;
    logic r_out_end;

    // Effective frame geometry.
    logic [XW-1:0]                w_ext;
    logic [YW-1:0]                h_ext;
    logic [CW-1:0]                w_eff;
    logic [RW-1:0]                h_eff;
    logic [bncd_pkg::BRD_W-1:0]   b_eff;

    // Accept stage signals.
    logic          col_busy;
    logic          accept;
    logic          s0_push;
    logic          s0_emit;
    logic          s0_inside;
    logic          s0_end;
    logic          s0_pix;
    logic [CW-1:0] col_sel;
    logic [RW-1:0] row_sel;
    logic [CW-1:0] ocol_sel;
    logic [RW-1:0] orow_sel;
    logic [CW-1:0] col_inc;
    logic [CW-1:0] ocol_inc;
    logic          ready;

    // Modify stage signals.
    logic                          s1_adv;
    logic [bncd_pkg::LS_W-1:0]     ls_rd_data;
    logic [bncd_pkg::LS_W-1:0]     ls_wr_data;
    logic [8:0]                    win_new;
    logic [bncd_pkg::NB_CNT_W-1:0] nb_cnt;
    logic                          s1_res;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width    <= bncd_pkg::RST_IMAGE_WIDTH;
            r_image_height   <= bncd_pkg::RST_IMAGE_HEIGHT;
            r_high_threshold <= bncd_pkg::RST_HIGH_THRESHOLD;
            r_low_threshold  <= bncd_pkg::RST_LOW_THRESHOLD;
            r_border_width   <= bncd_pkg::RST_BORDER_WIDTH;
        end else if (i_cfg_we) begin
            case (bncd_pkg::t_cfg_idx'(i_cfg_idx))
                bncd_pkg::CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[bncd_pkg::DIM_W-1:0];
                end
                bncd_pkg::CFG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data[bncd_pkg::DIM_W-1:0];
                end
                bncd_pkg::CFG_HIGH_THRESHOLD: begin
                    r_high_threshold <= i_cfg_data[bncd_pkg::THR_W-1:0];
                end
                bncd_pkg::CFG_LOW_THRESHOLD: begin
                    r_low_threshold <= i_cfg_data[bncd_pkg::THR_W-1:0];
                end
                bncd_pkg::CFG_BORDER_WIDTH: begin
                    r_border_width <= i_cfg_data[bncd_pkg::BRD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Clamp the frame size into the supported range; a zero border acts as one.
    always_comb begin
        w_ext = XW'(r_image_width);
        h_ext = YW'(r_image_height);
        if (w_ext < XW'(bncd_pkg::DIM_MIN)) begin
            w_eff = CW'(bncd_pkg::DIM_MIN);
        end else if (w_ext > XW'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(w_ext);
        end
        if (h_ext < YW'(bncd_pkg::DIM_MIN)) begin
            h_eff = RW'(bncd_pkg::DIM_MIN);
        end else if (h_ext > YW'(MAX_HEIGHT)) begin
            h_eff = RW'(MAX_HEIGHT);
        end else begin
            h_eff = RW'(h_ext);
        end
        b_eff = (r_border_width == '0) ? bncd_pkg::BRD_W'(1) : r_border_width;
    end

    // The input column is brought back below the width by repeated subtraction.
    assign col_busy = (r_in_col >= w_eff);

    // The modify stage moves on unless its result finds the output register full.
    assign s1_adv  = r_s1_valid && !(r_s1_emit && r_out_valid && i_stall);
    assign o_stall = col_busy || (r_s1_valid && !s1_adv);
    assign accept  = i_valid && !o_stall;

    // Accept stage: raster bookkeeping and the decision to push and to emit.
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        s0_push   = 1'b0;
        s0_emit   = 1'b0;
        s0_pix    = 1'b0;
        ready     = 1'b0;
        col_sel   = r_in_col;
        row_sel   = r_in_row;
        ocol_sel  = r_out_col;
        orow_sel  = r_out_row;
        if (!i_flush && i_start_frame) begin
            col_sel  = '0;
            row_sel  = '0;
            ocol_sel = '0;
            orow_sel = '0;
        end
        col_inc  = col_sel + CW'(1);
        ocol_inc = ocol_sel + CW'(1);

        if (col_busy) begin
            n_in_col = r_in_col - w_eff;
        end else if (accept) begin
            if (i_flush) begin
                // A flush pushes a black pixel only once the frame has fully entered.
                if (r_in_row >= h_eff && r_out_row < h_eff) begin
                    s0_push  = 1'b1;
                    s0_emit  = 1'b1;
                    n_in_col = (col_inc >= w_eff) ? '0 : col_inc;
                end
            end else begin
                n_in_col  = col_sel;
                n_in_row  = row_sel;
                n_out_col = ocol_sel;
                n_out_row = orow_sel;
                if (row_sel < h_eff) begin
                    s0_push = 1'b1;
                    s0_pix  = i_pixel_in;
                    ready   = (row_sel >= RW'(2)) ||
                              ((row_sel == RW'(1)) && (col_sel >= CW'(1)));
                    if (col_inc >= w_eff) begin
                        n_in_col = '0;
                        n_in_row = row_sel + RW'(1);
                    end else begin
                        n_in_col = col_inc;
                    end
                    s0_emit = ready && (orow_sel < h_eff);
                end
            end
            if (s0_emit) begin
                if (ocol_inc >= w_eff) begin
                    n_out_col = '0;
                    n_out_row = orow_sel + RW'(1);
                end else begin
                    n_out_col = ocol_inc;
                end
            end
        end

        // Position of the emitted pixel relative to the border and the frame end.
        s0_inside = ({1'b0, ocol_sel} >= (CW + 1)'(b_eff)) &&
                    (({1'b0, ocol_sel} + (CW + 1)'(b_eff)) < {1'b0, w_eff}) &&
                    ({1'b0, orow_sel} >= (RW + 1)'(b_eff)) &&
                    (({1'b0, orow_sel} + (RW + 1)'(b_eff)) < {1'b0, h_eff});
        s0_end    = (({1'b0, ocol_sel} + (CW + 1)'(1)) == {1'b0, w_eff}) &&
                    (({1'b0, orow_sel} + (RW + 1)'(1)) == {1'b0, h_eff});
    end

    // Raster counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // Stage handoff: an item that pushes a column moves to the modify stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= s0_push;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_emit   <= s0_emit;
            r_s1_inside <= s0_inside;
            r_s1_end    <= s0_end;
            r_s1_pix    <= s0_pix;
            r_s1_addr   <= col_sel[AW-1:0];
        end
    end

    // Line store: read in the accept cycle, shifted column written back as the modify stage advances.
    assign ls_wr_data = {ls_rd_data[0], r_s1_pix};

    bncd_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (col_sel[AW-1:0]),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (ls_wr_data),
        .o_rd_data (ls_rd_data)
    );

    // Window update, neighbor count and threshold decision.
    always_comb begin
        win_new = {r_s1_pix, ls_rd_data[0], ls_rd_data[1], r_window[8:3]};
        nb_cnt  = '0;
        for (int k = 0; k < 9; k++) begin
            if (k != 4) begin
                nb_cnt = nb_cnt + bncd_pkg::NB_CNT_W'(win_new[k]);
            end
        end
        s1_res = win_new[4];
        if (r_s1_inside) begin
            if (nb_cnt > r_high_threshold) begin
                s1_res = 1'b1;
            end else if (nb_cnt < r_low_threshold) begin
                s1_res = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
        end else if (s1_adv) begin
            r_window <= win_new;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            r_out_valid <= s1_adv && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((!r_out_valid || !i_stall) && s1_adv && r_s1_emit) begin
            r_out_pix <= s1_res;
            r_out_end <= r_s1_end;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pixel_out = r_out_pix;
    assign o_frame_end = r_out_end;

endmodule

`default_nettype wire
